// ===== rtl/esc_telemetry_frame_crc32_macros.svh =====
// Assertion macros shared by the telemetry frame receiver modules
`ifndef ESC_TELEMETRY_FRAME_CRC32_MACROS_SVH
`define ESC_TELEMETRY_FRAME_CRC32_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ETFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etfc assertion failed");
// next-cycle implication
`define ETFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etfc assertion failed");
`else
`define ETFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ETFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/etfc_pkg.sv =====
// Shared types, constants and functions of the telemetry frame receiver
package etfc_pkg;

  localparam int FRAME_BYTES = 38;
  localparam int CRC_BYTES   = 34;
  localparam int SYNC_BYTES  = 4;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int RPM_W       = 26;
  localparam int CFG_IDX_W   = 8;

  localparam logic [7:0]  AGE_LIMIT    = 8'd255;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] TIMEOUT_RST  = 32'd250000;
  localparam logic [2:0]  MIN_SYNC_RST = 3'd3;
  localparam logic [2:0]  SYNC_MAX     = 3'd7;

  localparam logic [7:0] SYNC_B0 = 8'h4B;
  localparam logic [7:0] SYNC_B1 = 8'h4F;
  localparam logic [7:0] SYNC_B2 = 8'h44;
  localparam logic [7:0] SYNC_B3 = 8'h4C;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for any 32-bit x
  localparam logic [31:0] DIV100_MUL   = 32'd1374389535;
  localparam int          DIV100_SHIFT = 37;

  // byte offsets of the frame fields
  localparam int F_RPM  = 4;
  localparam int F_VOLT = 8;
  localparam int F_CURR = 10;
  localparam int F_CAP  = 16;
  localparam int F_PWM  = 22;
  localparam int F_TFET = 26;
  localparam int F_TBEC = 27;

  // first frame position at which stored field bytes are read back
  localparam int RD_FIRST = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SYNC = CFG_IDX_W'(1);

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CRC_ERR  = 3'd2,
    ST_SYNC_ERR = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [31:0] now_us;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [RPM_W-1:0] rpm_hundreds;
    logic [15:0]      voltage;
    logic [15:0]      current;
    logic [15:0]      capacity;
    logic [15:0]      pwm_in;
    logic [7:0]       temp_fet;
    logic [7:0]       temp_bec;
    logic [7:0]       age;
  } out_word_t;

  // framer to field unit, registered in the cycle after acceptance
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] age;
    logic       rd;
    pos_t       rd_addr;
  } frm_ctl_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] sync_byte(logic [1:0] idx);
    logic [7:0] s;
    case (idx)
      2'd0:    s = SYNC_B0;
      2'd1:    s = SYNC_B1;
      2'd2:    s = SYNC_B2;
      default: s = SYNC_B3;
    endcase
    return s;
  endfunction

  // stored byte to read back while the frame byte at pos is written
  function automatic pos_t rd_sched(pos_t pos);
    pos_t a;
    case (pos)
      pos_t'(RD_FIRST):      a = pos_t'(F_RPM);
      pos_t'(RD_FIRST + 1):  a = pos_t'(F_RPM + 1);
      pos_t'(RD_FIRST + 2):  a = pos_t'(F_RPM + 2);
      pos_t'(RD_FIRST + 3):  a = pos_t'(F_RPM + 3);
      pos_t'(RD_FIRST + 4):  a = pos_t'(F_VOLT);
      pos_t'(RD_FIRST + 5):  a = pos_t'(F_VOLT + 1);
      pos_t'(RD_FIRST + 6):  a = pos_t'(F_CURR);
      pos_t'(RD_FIRST + 7):  a = pos_t'(F_CURR + 1);
      pos_t'(RD_FIRST + 8):  a = pos_t'(F_CAP);
      pos_t'(RD_FIRST + 9):  a = pos_t'(F_CAP + 1);
      pos_t'(RD_FIRST + 10): a = pos_t'(F_PWM);
      pos_t'(RD_FIRST + 11): a = pos_t'(F_PWM + 1);
      pos_t'(RD_FIRST + 12): a = pos_t'(F_TFET);
      pos_t'(RD_FIRST + 13): a = pos_t'(F_TBEC);
      default:               a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/etfc_in_if.sv =====
// Input word channel: function, received byte and time stamp
interface etfc_in_if;
  logic               valid;
  logic               ready;
  etfc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/etfc_out_if.sv =====
// Result word channel: status, decoded frame fields and data age
interface etfc_out_if;
  logic                valid;
  logic                ready;
  etfc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/etfc_cfg_if.sv =====
// Configuration write channel: register index and write data
interface etfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [etfc_pkg::CFG_IDX_W-1:0]   index;
  logic [31:0]                      wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/etfc_ram.sv =====
// Generic simple dual-port RAM with registered read data
module etfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/etfc_framer.sv =====
// Framer: sync check, CRC, frame position, timeout and data age
`include "esc_telemetry_frame_crc32_macros.svh"
module etfc_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  etfc_pkg::in_word_t  in_word,
  input  logic [31:0]         timeout_us,
  input  logic [2:0]          min_sync,
  output logic                ram_we,
  output etfc_pkg::pos_t      ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output etfc_pkg::pos_t      ram_raddr,
  output etfc_pkg::frm_ctl_t  ctl
);
  import etfc_pkg::*;

  pos_t        pos_r, pos_nxt;
  logic [2:0]  sync_r, sync_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        match_r, match_nxt;
  logic [31:0] lgt_r, lgt_nxt;
  logic [7:0]  age_r, age_nxt;
  frm_ctl_t    ctl_r;

  status_t     status;
  logic [31:0] crc_base;
  logic [31:0] diff;
  logic [1:0]  tail_lane;
  logic [7:0]  tail_byte;
  logic        tail_ok;
  logic [7:0]  b;

  assign b         = in_word.data_byte;
  // byte 34 holds the low byte of the inverted CRC
  assign tail_lane = pos_r[1:0] - 2'd2;
  assign tail_byte = ~crc_r[{tail_lane, 3'b000} +: 8];
  assign tail_ok   = (b == tail_byte);

  always_comb begin
    pos_nxt   = pos_r;
    sync_nxt  = sync_r;
    crc_nxt   = crc_r;
    match_nxt = match_r;
    lgt_nxt   = lgt_r;
    age_nxt   = age_r;
    status    = ST_NONE;
    crc_base  = (pos_r == '0) ? CRC_INIT : crc_r;
    diff      = in_word.now_us - lgt_r;
    if (acc) begin
      if (in_word.func) begin
        if (!diff[31] && (diff > timeout_us)) begin
          if (age_r != AGE_LIMIT) begin
            age_nxt = age_r + 8'd1;
          end
          pos_nxt  = '0;
          sync_nxt = '0;
          lgt_nxt  = in_word.now_us;
          status   = ST_TIMEOUT;
        end
      end else begin
        if (pos_r < pos_t'(CRC_BYTES)) begin
          crc_nxt = crc_byte(crc_base, b);
        end
        // accumulate the compare of the trailing CRC bytes
        match_nxt = (pos_r == pos_t'(CRC_BYTES)) ? tail_ok : (match_r & tail_ok);
        pos_nxt   = pos_r + pos_t'(1);
        if (pos_r < pos_t'(SYNC_BYTES)) begin
          if (b != sync_byte(pos_r[1:0])) begin
            pos_nxt  = '0;
            sync_nxt = '0;
            status   = ST_SYNC_ERR;
          end else if ((pos_r == pos_t'(SYNC_BYTES - 1)) && (sync_r != SYNC_MAX)) begin
            sync_nxt = sync_r + 3'd1;
          end
        end else if (pos_r == pos_t'(FRAME_BYTES - 1)) begin
          pos_nxt = '0;
          if (sync_r > min_sync) begin
            if (match_r && tail_ok) begin
              status  = ST_GOOD;
              age_nxt = '0;
              lgt_nxt = in_word.now_us;
            end else begin
              status = ST_CRC_ERR;
            end
          end
        end
      end
    end
  end

  assign ram_we    = acc && !in_word.func;
  assign ram_waddr = pos_r;
  assign ram_wdata = b;
  // field bytes are read back while the tail of the same frame arrives
  assign ram_re    = acc && !in_word.func && (pos_r >= pos_t'(RD_FIRST));
  assign ram_raddr = rd_sched(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      sync_r        <= '0;
      crc_r         <= CRC_INIT;
      lgt_r         <= '0;
      age_r         <= AGE_LIMIT;
      ctl_r         <= '0;
    end else begin
      pos_r         <= pos_nxt;
      sync_r        <= sync_nxt;
      crc_r         <= crc_nxt;
      lgt_r         <= lgt_nxt;
      age_r         <= age_nxt;
      ctl_r.valid   <= acc;
      ctl_r.status  <= status;
      ctl_r.age     <= age_nxt;
      ctl_r.rd      <= ram_re;
      ctl_r.rd_addr <= ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
  end

  assign ctl = ctl_r;

  `ETFC_ASSERT_IMP(a_rd_behind_wr, clk, rst_n, ram_re, ram_raddr < pos_r)
  `ETFC_ASSERT_NXT(a_good_clears_age, clk, rst_n, acc && (status == ST_GOOD), (age_r == '0) && (lgt_r == $past(in_word.now_us)))
  `ETFC_ASSERT_NXT(a_sync_err_clears, clk, rst_n, acc && (status == ST_SYNC_ERR), (pos_r == '0) && (sync_r == '0))

endmodule

// ===== rtl/etfc_fields.sv =====
// Field unit: collects stored bytes, divides rpm by 100, builds result words
module etfc_fields (
  input  logic                clk,
  input  etfc_pkg::frm_ctl_t  ctl,
  input  logic [7:0]          rdata,
  output logic                push,
  output etfc_pkg::out_word_t push_word
);
  import etfc_pkg::*;

  logic [31:0] rpm_raw_r;
  logic [15:0] volt_r;
  logic [15:0] curr_r;
  logic [15:0] cap_r;
  logic [15:0] pwm_r;
  logic [7:0]  tfet_r;
  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.rd) begin
      case (ctl.rd_addr)
        pos_t'(F_RPM):      rpm_raw_r[7:0]   <= rdata;
        pos_t'(F_RPM + 1):  rpm_raw_r[15:8]  <= rdata;
        pos_t'(F_RPM + 2):  rpm_raw_r[23:16] <= rdata;
        pos_t'(F_RPM + 3):  rpm_raw_r[31:24] <= rdata;
        pos_t'(F_VOLT):     volt_r[7:0]      <= rdata;
        pos_t'(F_VOLT + 1): volt_r[15:8]     <= rdata;
        pos_t'(F_CURR):     curr_r[7:0]      <= rdata;
        pos_t'(F_CURR + 1): curr_r[15:8]     <= rdata;
        pos_t'(F_CAP):      cap_r[7:0]       <= rdata;
        pos_t'(F_CAP + 1):  cap_r[15:8]      <= rdata;
        pos_t'(F_PWM):      pwm_r[7:0]       <= rdata;
        pos_t'(F_PWM + 1):  pwm_r[15:8]      <= rdata;
        pos_t'(F_TFET):     tfet_r           <= rdata;
        default: ;
      endcase
    end
    // rpm settles many words before the frame ends
    prod_r <= {32'd0, rpm_raw_r} * {32'd0, DIV100_MUL};
  end

  always_comb begin
    push_word        = '0;
    push_word.status = ctl.status;
    push_word.age    = ctl.age;
    if (ctl.status == ST_GOOD) begin
      push_word.rpm_hundreds = prod_r[DIV100_SHIFT +: RPM_W];
      push_word.voltage      = volt_r;
      push_word.current      = curr_r;
      push_word.capacity     = cap_r;
      push_word.pwm_in       = pwm_r;
      push_word.temp_fet     = tfet_r;
      // last byte read on the final frame word comes straight from the RAM
      push_word.temp_bec     = rdata;
    end
  end

  assign push = ctl.valid;

endmodule

// ===== rtl/etfc_outbuf.sv =====
// Two-entry result buffer: output register plus skid entry
`include "esc_telemetry_frame_crc32_macros.svh"
module etfc_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  etfc_pkg::out_word_t push_word,
  input  logic                out_ready,
  output logic                out_valid,
  output etfc_pkg::out_word_t out_word,
  output logic                can_take
);
  import etfc_pkg::*;

  logic      head_valid_r;
  logic      skid_valid_r;
  out_word_t head_r;
  out_word_t skid_r;
  logic      pop;
  logic [1:0] occ;
  logic [1:0] occ_after;

  assign pop       = head_valid_r && out_ready;
  // words in flight: the one in the field stage plus the buffered ones
  assign occ       = {1'b0, push} + {1'b0, head_valid_r} + {1'b0, skid_valid_r};
  assign occ_after = occ - {1'b0, pop};
  assign can_take  = (occ_after < 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        skid_r <= push_word;
      end else begin
        head_r <= push_word;
      end
    end else if (push) begin
      skid_r <= push_word;
    end
  end

  assign out_valid = head_valid_r;
  assign out_word  = head_r;

  `ETFC_ASSERT_IMP(a_skid_needs_head, clk, rst_n, skid_valid_r, head_valid_r)
  `ETFC_ASSERT_IMP(a_no_overflow, clk, rst_n, head_valid_r && skid_valid_r && !pop, !push)
  `ETFC_ASSERT_NXT(a_skid_moves_up, clk, rst_n, pop && skid_valid_r, head_valid_r)

endmodule

// ===== rtl/esc_telemetry_frame_crc32.sv =====
// Telemetry frame receiver with CRC-32 check. Takes one word per clock unless the
// input is held off: either a received byte or a time check. Sustained rate is one
// word per cycle while the result side takes its words; each word yields exactly one
// result word, registered in the framer register and then in the result register.
// The 38 frame bytes are written into a 38x8 RAM as they arrive; the fourteen field
// bytes are read back through its single read port while the last fourteen bytes of
// the same frame come in, so a complete frame gives its decoded fields without a
// separate read pass. The input holds off when two result words would still be held
// after this cycle's output transfer, counting the one in the field stage. No clearing
// pass is needed after reset. Configuration writes are always taken and take effect at
// once; write them only while no word is in flight.
module esc_telemetry_frame_crc32 (
  input  logic   clk,
  input  logic   rst_n,
  etfc_in_if.sink     in_ch,
  etfc_out_if.source  out_ch,
  etfc_cfg_if.sink    cfg_ch
);
  import etfc_pkg::*;

  logic [31:0] timeout_r;
  logic [2:0]  min_sync_r;

  logic        acc;
  logic        ram_we;
  pos_t        ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  pos_t        ram_raddr;
  logic [7:0]  ram_rdata;
  frm_ctl_t    ctl;
  logic        push;
  out_word_t   push_word;
  logic        can_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      min_sync_r <= MIN_SYNC_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TIMEOUT:  timeout_r  <= cfg_ch.wdata;
        REG_MIN_SYNC: min_sync_r <= cfg_ch.wdata[2:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && can_take;

  etfc_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_word    (in_ch.data),
    .timeout_us (timeout_r),
    .min_sync   (min_sync_r),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ctl        (ctl)
  );

  etfc_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  etfc_fields u_fields (
    .clk       (clk),
    .ctl       (ctl),
    .rdata     (ram_rdata),
    .push      (push),
    .push_word (push_word)
  );

  etfc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.data),
    .can_take  (can_take)
  );

endmodule

// ===== tb/tb_esc_telemetry_frame_crc32.sv =====
// Self-checking testbench for the telemetry frame receiver with CRC-32 check
module tb_esc_telemetry_frame_crc32;
  timeunit 1ns;
  timeprecision 1ps;

  import etfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_WORDS = 220;
  localparam int unsigned NUM_PHASES  = 5;
  localparam logic [7:0] SYNC_WORD [4] = '{SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3};

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  typedef struct {
    bit        typed;
    out_word_t res;
  } word_tag_t;

  typedef struct {
    logic [31:0] tmo;
    logic [2:0]  min_sync;
    int unsigned span;
  } phase_cfg_t;

  logic clk;
  logic rst_n;

  etfc_in_if  in_ch();
  etfc_out_if out_ch();
  etfc_cfg_if cfg_ch();

  esc_telemetry_frame_crc32 DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // receiver model state
  logic [5:0]  frm_pos;
  logic [2:0]  sync_cnt;
  logic [31:0] crc_acc;
  logic [7:0]  frame_buf [FRAME_BYTES];
  logic [31:0] last_good_us;
  logic [7:0]  data_age_q;
  logic [31:0] cfg_timeout;
  logic [2:0]  cfg_min_sync;

  out_word_t   result_q [$];
  word_tag_t   tag_q [$];
  out_word_t   pred;
  word_tag_t   tag;
  out_word_t   want;
  out_word_t   got;

  int unsigned n_sent, n_results, n_mismatch, cycle_cnt;
  int unsigned n_good, n_crc_err, n_sync_err, n_timeout;
  int unsigned burst_left;
  logic [31:0] sim_us;

  function automatic logic [31:0] crc32_step(logic [31:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic logic [15:0] stored_le16(int i);
    return {frame_buf[i + 1], frame_buf[i]};
  endfunction

  task automatic predict_result(input in_word_t w, output out_word_t r);
    logic [31:0] dt;
    logic [31:0] raw_rpm;
    int p;
    r = '0;
    r.status = ST_NONE;
    if (w.func) begin
      dt = w.now_us - last_good_us;
      if (!dt[31] && dt > cfg_timeout) begin
        if (data_age_q != AGE_LIMIT) data_age_q = data_age_q + 8'd1;
        frm_pos = '0;
        sync_cnt = '0;
        last_good_us = w.now_us;
        r.status = ST_TIMEOUT;
      end
    end else begin
      p = (frm_pos >= FRAME_BYTES) ? 0 : int'(frm_pos);
      frame_buf[p] = w.data_byte;
      if (p < CRC_BYTES) crc_acc = crc32_step((p == 0) ? CRC_INIT : crc_acc, w.data_byte);
      p++;
      frm_pos = 6'(p);
      if (p <= SYNC_BYTES) begin
        if (w.data_byte != SYNC_WORD[p - 1]) begin
          frm_pos = '0;
          sync_cnt = '0;
          r.status = ST_SYNC_ERR;
        end else if (p == SYNC_BYTES && sync_cnt != SYNC_MAX) begin
          sync_cnt = sync_cnt + 3'd1;
        end
      end else if (p == FRAME_BYTES) begin
        frm_pos = '0;
        if (sync_cnt > cfg_min_sync) begin
          if (~crc_acc == {stored_le16(CRC_BYTES + 2), stored_le16(CRC_BYTES)}) begin
            raw_rpm        = {stored_le16(F_RPM + 2), stored_le16(F_RPM)};
            r.status       = ST_GOOD;
            r.rpm_hundreds = RPM_W'(raw_rpm / 32'd100);
            r.voltage      = stored_le16(F_VOLT);
            r.current      = stored_le16(F_CURR);
            r.capacity     = stored_le16(F_CAP);
            r.pwm_in       = stored_le16(F_PWM);
            r.temp_fet     = frame_buf[F_TFET];
            r.temp_bec     = frame_buf[F_TBEC];
            data_age_q     = '0;
            last_good_us   = w.now_us;
          end else begin
            r.status = ST_CRC_ERR;
          end
        end
      end
    end
    r.age = data_age_q;
  endtask

  function automatic dir_row_t drow(bit f, logic [7:0] b, logic [31:0] t, bit typed,
                                    status_t st);
    dir_row_t d;
    d.w.func      = f;
    d.w.data_byte = b;
    d.w.now_us    = t;
    d.typed       = typed;
    d.res         = '0;
    d.res.status  = st;
    d.res.age     = AGE_LIMIT;
    return d;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_result(in_ch.data, pred);
      tag = tag_q.pop_front();
      result_q.push_back(tag.typed ? tag.res : pred);
      case (pred.status)
        ST_GOOD:     n_good++;
        ST_CRC_ERR:  n_crc_err++;
        ST_SYNC_ERR: n_sync_err++;
        ST_TIMEOUT:  n_timeout++;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_TIMEOUT:  cfg_timeout = cfg_ch.wdata;
        REG_MIN_SYNC: cfg_min_sync = cfg_ch.wdata[2:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_results++;
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result %0d arrived with nothing expected: status %0d age %0d",
                   n_results, got.status, got.age);
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status || got.rpm_hundreds !== want.rpm_hundreds ||
            got.voltage !== want.voltage || got.current !== want.current ||
            got.capacity !== want.capacity || got.pwm_in !== want.pwm_in ||
            got.temp_fet !== want.temp_fet || got.temp_bec !== want.temp_bec ||
            got.age !== want.age) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result %0d mismatch, expected: st %0d rpm %0d v %h i %h cap %h pwm %h",
                     n_results, want.status, want.rpm_hundreds, want.voltage,
                     want.current, want.capacity, want.pwm_in);
            $display("  tfet %h tbec %h age %0d | got: st %0d rpm %0d v %h i %h cap %h",
                     want.temp_fet, want.temp_bec, want.age, got.status,
                     got.rpm_hundreds, got.voltage, got.current, got.capacity);
            $display("  pwm %h tfet %h tbec %h age %0d",
                     got.pwm_in, got.temp_fet, got.temp_bec, got.age);
          end
        end
      end
    end
  end

  // result side: changing stall pattern, plus one long hold-off to back up the input
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit held;
    rx_cycle = 0;
    hold_left = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!held && n_results >= 400) begin
        held = 1'b1;
        hold_left = 240;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
          2'd2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (rx_cycle[3:0] < 4'd11);
        endcase
      end
    end
  end

  // offer one word; return in the step it is taken, valid still high
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t res = '0);
    int unsigned gap;
    word_tag_t t;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    t.typed = typed;
    t.res = res;
    tag_q.push_back(t);
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    n_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_word_t w;
    sim_us = sim_us + $urandom_range(0, 50);
    w.func = 1'b0;
    w.data_byte = b;
    w.now_us = sim_us;
    send_word(w);
  endtask

  task automatic send_check(input int unsigned span);
    in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.func = 1'b1;
    w.data_byte = 8'($urandom_range(0, 255));
    if (pick < 70) begin
      sim_us = sim_us + $urandom_range(0, span);
      w.now_us = sim_us;
    end else if (pick < 85) begin
      w.now_us = sim_us - $urandom_range(1, span);
    end else begin
      w.now_us = $urandom();
    end
    send_word(w);
  endtask

  // build a frame with a valid CRC, optionally damage it, send the first len bytes
  task automatic send_frame(input bit corrupt, input int len, input int unsigned span);
    logic [7:0] fb [FRAME_BYTES];
    logic [31:0] c;
    int fill;
    int chk_at;
    fill = $urandom_range(0, 5);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i < SYNC_BYTES) fb[i] = SYNC_WORD[i];
      else if (fill == 0) fb[i] = 8'hFF;
      else if (fill == 1) fb[i] = 8'h00;
      else fb[i] = 8'($urandom_range(0, 255));
    end
    c = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) c = crc32_step(c, fb[i]);
    c = ~c;
    for (int i = 0; i < 4; i++) fb[CRC_BYTES + i] = c[8*i +: 8];
    if (corrupt) begin
      c[4:0] = 5'($urandom_range(0, 7));
      fb[$urandom_range(SYNC_BYTES, FRAME_BYTES - 1)] ^= 8'(1 << c[2:0]);
    end
    chk_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, len - 1)) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == chk_at) send_check(span);
      send_byte(fb[i]);
    end
  endtask

  task automatic send_bad_sync();
    int k;
    logic [7:0] bad;
    k = $urandom_range(0, SYNC_BYTES - 1);
    for (int i = 0; i < k; i++) send_byte(SYNC_WORD[i]);
    bad = 8'($urandom_range(0, 255));
    if (bad == SYNC_WORD[k]) bad = bad ^ 8'h01;
    send_byte(bad);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // drop valid and wait until every result is back and the pipeline is empty
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (n_results < n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    dir_row_t dir_tab [];
    phase_cfg_t phases [NUM_PHASES];
    int unsigned start;
    int unsigned kind;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    frm_pos = '0;
    sync_cnt = '0;
    crc_acc = CRC_INIT;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    last_good_us = '0;
    data_age_q = AGE_LIMIT;
    cfg_timeout = TIMEOUT_RST;
    cfg_min_sync = MIN_SYNC_RST;
    sim_us = '0;
    burst_left = 0;

    dir_tab = '{
      drow(1, 8'h00, 32'd0,        1, ST_NONE),
      drow(1, 8'hFF, 32'd250000,   1, ST_NONE),     // equal to timeout: no fire
      drow(1, 8'h00, 32'd250001,   1, ST_TIMEOUT),  // age already saturated
      drow(1, 8'hFF, 32'd0,        1, ST_NONE),     // negative difference
      drow(1, 8'h5A, 32'hFFFFFFFF, 1, ST_NONE),
      drow(1, 8'hA5, 32'h7FFFFFFF, 1, ST_TIMEOUT),
      drow(1, 8'h00, 32'hFFFFFFFF, 1, ST_NONE),     // difference is most negative
      drow(0, 8'h00, 32'd0,        1, ST_SYNC_ERR),
      drow(0, 8'hFF, 32'hFFFFFFFF, 1, ST_SYNC_ERR),
      drow(0, SYNC_B0, 32'd1,      0, ST_NONE),
      drow(0, SYNC_B1, 32'd2,      0, ST_NONE),
      drow(0, SYNC_B2, 32'd3,      0, ST_NONE),
      drow(0, 8'h00, 32'd4,        1, ST_SYNC_ERR), // last sync byte wrong
      drow(0, SYNC_B3, 32'd5,      1, ST_SYNC_ERR), // sync byte out of order
      drow(0, SYNC_B0, 32'd6,      0, ST_NONE),
      drow(0, SYNC_B1, 32'd7,      0, ST_NONE),
      drow(0, SYNC_B2, 32'd8,      0, ST_NONE),
      drow(0, SYNC_B3, 32'd9,      0, ST_NONE),
      drow(0, 8'hFF, 32'd10,       0, ST_NONE),
      drow(0, 8'h00, 32'd11,       0, ST_NONE),
      drow(0, 8'hAA, 32'd12,       0, ST_NONE),
      drow(0, 8'h55, 32'd13,       0, ST_NONE),
      drow(1, 8'hFF, 32'h8003D091, 1, ST_TIMEOUT),  // timeout mid-frame clears framer
      drow(0, SYNC_B0, 32'h8003D092, 0, ST_NONE),
      drow(0, SYNC_B1, 32'h8003D093, 0, ST_NONE)
    };

    phases[0] = '{tmo: TIMEOUT_RST,  min_sync: MIN_SYNC_RST, span: 400000};
    phases[1] = '{tmo: 32'd1,        min_sync: 3'd0,         span: 20};
    phases[2] = '{tmo: 32'hFFFFFFFF, min_sync: 3'd7,         span: 32'h40000000};
    phases[3] = '{tmo: 32'd5000,     min_sync: 3'd1,         span: 9000};
    phases[4] = '{tmo: 32'd100000,   min_sync: 3'd2,         span: 180000};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
    settle_block();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        settle_block();
        write_reg(REG_TIMEOUT, phases[ph].tmo);
        if (ph == 3) begin
          // writes to indexes past the register list must be ignored
          write_reg(CFG_IDX_W'(2), 32'hFFFFFFFF);
          write_reg(CFG_IDX_W'(255), 32'h0);
        end
        write_reg(REG_MIN_SYNC, 32'(phases[ph].min_sync));
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
      end
      sim_us = $urandom();
      start = n_sent;
      while (n_sent - start < PHASE_WORDS) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) send_frame(1'b0, FRAME_BYTES, phases[ph].span);
        else if (kind < 72) send_frame(1'b1, FRAME_BYTES, phases[ph].span);
        else if (kind < 80) send_bad_sync();
        else if (kind < 90) repeat ($urandom_range(1, 3)) send_check(phases[ph].span);
        else if (kind < 95) repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        else send_frame(1'b0, $urandom_range(5, FRAME_BYTES - 1), phases[ph].span);
      end
    end

    settle_block();
    if (result_q.size() != 0) begin
      n_mismatch += result_q.size();
      $display("%0d expected results never arrived", result_q.size());
    end

    $display("covered %0d words over %0d register settings, %0d results checked",
             n_sent, NUM_PHASES, n_results);
    $display("frames taken %0d, crc errors %0d, sync errors %0d, timeouts %0d, mismatches %0d",
             n_good, n_crc_err, n_sync_err, n_timeout, n_mismatch);
    if (n_mismatch == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
